// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- src/ladlk_pkg.sv -----
`default_nettype none
package ladlk_pkg;

  localparam int COORD_W     = 24;
  localparam int NORM_W      = 18;
  localparam int OUT_W       = 40;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * COORD_W + 1;
  localparam int Q_W         = 2 * COORD_W + 2;
  localparam int Q_EVEN      = Q_W + (Q_W % 2);
  localparam int DOT_W       = DIFF_W + NORM_W;
  localparam int S_W         = DOT_W + 2;
  localparam int NORM_LEVELS = $clog2(Q_EVEN / 2);
  localparam int NORM_SPLIT  = NORM_LEVELS / 2;
  localparam int J_W         = NORM_LEVELS;
  localparam int QN_W        = 62;
  localparam int K_OFF       = (QN_W - Q_EVEN) / 2;
  localparam int SH_W        = 9;
  localparam int SH_MAX      = 92;
  localparam int N_W         = S_W + SH_MAX;
  localparam int R0_W        = N_W - OUT_W;
  localparam int ROOT_W      = 32;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STEPS  = 4;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
  localparam int HI_W        = 32;
  localparam int P_W         = 63;
  localparam int PHI_W       = 31;
  localparam int PI_W        = 32;
  localparam int DEN_W       = 63;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = OUT_W / DIV_STEPS;

  // 4*pi in Q28.
  localparam logic [PI_W-1:0] FOUR_PI_Q28 = 32'd3373259426;

  typedef struct packed {
    logic [S_W-1:0]         mag;
    logic                   neg;
    logic                   singular;
    logic signed [SH_W-1:0] sh;
    logic [HI_W-1:0]        qhi;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  x;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sqrt_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [OUT_W-1:0] lo;
    logic [OUT_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             singular;
    logic             ovf;
  } div_t;

  // One restoring square-root digit.
  function automatic sqrt_t sqrt_iter(input sqrt_t s);
    sqrt_t o;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    logic ge;
    rem2   = {s.rem[REM_W-3:0], s.x[RAD_W-1 -: 2]};
    trial  = {s.root, 2'b01};
    ge     = (rem2 >= trial);
    o.x    = s.x << 2;
    o.root = {s.root[ROOT_W-2:0], ge};
    o.rem  = ge ? (rem2 - trial) : rem2;
    return o;
  endfunction

  // One restoring division bit.
  function automatic div_t div_iter(input div_t s);
    div_t o;
    logic [DEN_W:0] rem2;
    logic [DEN_W:0] diff;
    logic ge;
    rem2  = {s.rem, s.lo[OUT_W-1]};
    diff  = rem2 - {1'b0, s.den};
    ge    = (rem2 >= {1'b0, s.den});
    o     = s;
    o.rem = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
    o.lo  = s.lo << 1;
    o.quo = {s.quo[OUT_W-2:0], ge};
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- src/ladlk_front.sv -----
`default_nettype none
module ladlk_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic signed [ladlk_pkg::COORD_W-1:0]    test_x,
  input  logic signed [ladlk_pkg::COORD_W-1:0]    test_y,
  input  logic signed [ladlk_pkg::COORD_W-1:0]    test_z,
  input  logic signed [ladlk_pkg::COORD_W-1:0]    trial_x,
  input  logic signed [ladlk_pkg::COORD_W-1:0]    trial_y,
  input  logic signed [ladlk_pkg::COORD_W-1:0]    trial_z,
  input  logic signed [ladlk_pkg::NORM_W-1:0]     normal_x,
  input  logic signed [ladlk_pkg::NORM_W-1:0]     normal_y,
  input  logic signed [ladlk_pkg::NORM_W-1:0]     normal_z,
  output logic                                    out_valid,
  output logic [ladlk_pkg::Q_W-1:0]               q,
  output logic signed [ladlk_pkg::S_W-1:0]        s
);

  logic signed [ladlk_pkg::DIFF_W-1:0]   u [3];
  logic signed [ladlk_pkg::NORM_W-1:0]   m [3];
  logic signed [2*ladlk_pkg::DIFF_W-1:0] sqf [3];
  logic [ladlk_pkg::SQ_W-1:0]            sq [3];
  logic signed [ladlk_pkg::DOT_W-1:0]    dot [3];
  logic                                  v1;

  always_comb begin
    u[0] = {test_x[ladlk_pkg::COORD_W-1], test_x} - {trial_x[ladlk_pkg::COORD_W-1], trial_x};
    u[1] = {test_y[ladlk_pkg::COORD_W-1], test_y} - {trial_y[ladlk_pkg::COORD_W-1], trial_y};
    u[2] = {test_z[ladlk_pkg::COORD_W-1], test_z} - {trial_z[ladlk_pkg::COORD_W-1], trial_z};
    m[0] = normal_x;
    m[1] = normal_y;
    m[2] = normal_z;
    for (int i = 0; i < 3; i++) begin
      sqf[i] = u[i] * u[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i]  <= sqf[i][ladlk_pkg::SQ_W-1:0];
        dot[i] <= u[i] * m[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= ladlk_pkg::Q_W'(sq[0]) + ladlk_pkg::Q_W'(sq[1]) + ladlk_pkg::Q_W'(sq[2]);
      s <= ladlk_pkg::S_W'(dot[0]) + ladlk_pkg::S_W'(dot[1]) + ladlk_pkg::S_W'(dot[2]);
    end
  end

endmodule
`default_nettype wire

// ----- src/ladlk_norm.sv -----
`default_nettype none
module ladlk_norm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [ladlk_pkg::Q_W-1:0]        q,
  input  logic signed [ladlk_pkg::S_W-1:0] s,
  output logic                             out_valid,
  output ladlk_pkg::side_t                 side,
  output ladlk_pkg::sqrt_t                 init
);

  logic [ladlk_pkg::Q_EVEN-1:0]      xa_next, xa, xb;
  logic [ladlk_pkg::J_W-1:0]         ja_next, ja, jb;
  logic [ladlk_pkg::S_W-1:0]         mag;
  logic                              neg, singular, va;
  logic [ladlk_pkg::Q_EVEN+ladlk_pkg::QN_W-1:0] wide;
  logic [ladlk_pkg::QN_W-1:0]        qn;
  logic signed [ladlk_pkg::SH_W-1:0] kk, sh;

  // Leading-zero search in pairs of bits, upper levels in the first stage.
  always_comb begin
    xa_next = ladlk_pkg::Q_EVEN'(q);
    ja_next = '0;
    for (int l = ladlk_pkg::NORM_LEVELS - 1; l >= ladlk_pkg::NORM_SPLIT; l--) begin
      if ((xa_next >> (ladlk_pkg::Q_EVEN - (2 << l))) == '0) begin
        xa_next = xa_next << (2 << l);
        ja_next = ja_next | (ladlk_pkg::J_W'(1) << l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa       <= xa_next;
      ja       <= ja_next;
      neg      <= (s > 0);
      mag      <= s[ladlk_pkg::S_W-1] ? ladlk_pkg::S_W'(-s) : ladlk_pkg::S_W'(s);
      singular <= (q == '0);
    end
  end

  always_comb begin
    xb = xa;
    jb = ja;
    for (int l = ladlk_pkg::NORM_SPLIT - 1; l >= 0; l--) begin
      if ((xb >> (ladlk_pkg::Q_EVEN - (2 << l))) == '0) begin
        xb = xb << (2 << l);
        jb = jb | (ladlk_pkg::J_W'(1) << l);
      end
    end
    wide = {xb, {ladlk_pkg::QN_W{1'b0}}};
    qn   = wide[ladlk_pkg::Q_EVEN+ladlk_pkg::QN_W-1 -: ladlk_pkg::QN_W];
    kk   = $signed(ladlk_pkg::SH_W'(jb)) + ladlk_pkg::SH_W'(ladlk_pkg::K_OFF);
    sh   = kk + kk + kk + ladlk_pkg::SH_W'(2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.mag      <= mag;
      side.neg      <= neg;
      side.singular <= singular;
      side.sh       <= sh;
      side.qhi      <= qn[ladlk_pkg::QN_W-1 -: ladlk_pkg::HI_W];
      init.x        <= ladlk_pkg::RAD_W'(qn);
      init.root     <= '0;
      init.rem      <= '0;
    end
  end

endmodule
`default_nettype wire

// ----- src/ladlk_sqrt_step.sv -----
`default_nettype none
module ladlk_sqrt_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ladlk_pkg::sqrt_t in_s,
  input  ladlk_pkg::side_t in_side,
  output logic             out_valid,
  output ladlk_pkg::sqrt_t out_s,
  output ladlk_pkg::side_t out_side
);

  ladlk_pkg::sqrt_t s_next;

  always_comb begin
    s_next = in_s;
    for (int i = 0; i < ladlk_pkg::SQRT_STEPS; i++) begin
      s_next = ladlk_pkg::sqrt_iter(s_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_s    <= s_next;
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

// ----- src/ladlk_div_step.sv -----
`default_nettype none
module ladlk_div_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ladlk_pkg::div_t in_d,
  output logic            out_valid,
  output ladlk_pkg::div_t out_d
);

  ladlk_pkg::div_t d_next;

  always_comb begin
    d_next = in_d;
    for (int i = 0; i < ladlk_pkg::DIV_STEPS; i++) begin
      d_next = ladlk_pkg::div_iter(d_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/laplace_adjoint_double_layer_kernel.sv -----
// Laplace adjoint double-layer kernel K = -((t - s) . n) / (4 pi |t - s|^3).
// Input channel: in_valid / in_ready carry one request made of a test point,
// a trial point (signed Q8.16) and the test normal (signed Q2.16).
// Output channel: out_valid / out_ready carry kernel_value (signed Q20.20,
// rounded toward zero) with the singular and saturated flags.
// One request enters per clock while in_ready is high; the pipeline is 27
// register stages deep. Most of the depth is the square root (eight stages
// of four digits) and the division (ten stages of four quotient bits).
// Coinciding points give 0 with singular set; a value beyond the Q20.20
// range is clipped to the nearest end with saturated set.
// Reset clears every valid bit; the pipeline is empty afterwards.
// The whole pipeline advances together: while a result is held by a low
// out_ready, in_ready is low and every stage keeps its contents.
`default_nettype none
module laplace_adjoint_double_layer_kernel (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ladlk_pkg::COORD_W-1:0] test_x,
  input  logic signed [ladlk_pkg::COORD_W-1:0] test_y,
  input  logic signed [ladlk_pkg::COORD_W-1:0] test_z,
  input  logic signed [ladlk_pkg::COORD_W-1:0] trial_x,
  input  logic signed [ladlk_pkg::COORD_W-1:0] trial_y,
  input  logic signed [ladlk_pkg::COORD_W-1:0] trial_z,
  input  logic signed [ladlk_pkg::NORM_W-1:0]  normal_x,
  input  logic signed [ladlk_pkg::NORM_W-1:0]  normal_y,
  input  logic signed [ladlk_pkg::NORM_W-1:0]  normal_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ladlk_pkg::OUT_W-1:0]   kernel_value,
  output logic                                 singular,
  output logic                                 saturated
);

  logic                             en;
  logic                             f_valid;
  logic [ladlk_pkg::Q_W-1:0]        f_q;
  logic signed [ladlk_pkg::S_W-1:0] f_s;

  logic             sq_v    [ladlk_pkg::SQRT_STAGES+1];
  ladlk_pkg::sqrt_t sq_s    [ladlk_pkg::SQRT_STAGES+1];
  ladlk_pkg::side_t sq_side [ladlk_pkg::SQRT_STAGES+1];

  logic                          m1_v, m2_v, m3_v;
  logic [ladlk_pkg::P_W-1:0]     p;
  logic [ladlk_pkg::DEN_W-1:0]   den2, den3;
  ladlk_pkg::side_t              side1, side2, side3;
  logic [ladlk_pkg::N_W-1:0]     n_next, n3;
  logic [ladlk_pkg::R0_W-1:0]    r0;
  logic                          ovf;
  ladlk_pkg::div_t               d_init;

  logic            dv_v [ladlk_pkg::DIV_STAGES+1];
  ladlk_pkg::div_t dv_d [ladlk_pkg::DIV_STAGES+1];

  ladlk_pkg::div_t               fin;
  logic [ladlk_pkg::OUT_W-1:0]   limit, qsat, val;
  logic                          sat;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ladlk_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .test_x   (test_x),
    .test_y   (test_y),
    .test_z   (test_z),
    .trial_x  (trial_x),
    .trial_y  (trial_y),
    .trial_z  (trial_z),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z),
    .out_valid(f_valid),
    .q        (f_q),
    .s        (f_s)
  );

  ladlk_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .q        (f_q),
    .s        (f_s),
    .out_valid(sq_v[0]),
    .side     (sq_side[0]),
    .init     (sq_s[0])
  );

  for (genvar g = 0; g < ladlk_pkg::SQRT_STAGES; g++) begin : g_sqrt
    ladlk_sqrt_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sq_v[g]),
      .in_s     (sq_s[g]),
      .in_side  (sq_side[g]),
      .out_valid(sq_v[g+1]),
      .out_s    (sq_s[g+1]),
      .out_side (sq_side[g+1])
    );
  end

  // Denominator: (Qn >> 30) * r, then the top of that times 4*pi.
  always_comb begin
    n_next = side2.sh[ladlk_pkg::SH_W-1]
           ? (ladlk_pkg::N_W'(side2.mag) >> (-side2.sh))
           : (ladlk_pkg::N_W'(side2.mag) << side2.sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
    end else if (en) begin
      m1_v <= sq_v[ladlk_pkg::SQRT_STAGES];
      m2_v <= m1_v;
      m3_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p     <= sq_side[ladlk_pkg::SQRT_STAGES].qhi
             * sq_s[ladlk_pkg::SQRT_STAGES].root[ladlk_pkg::ROOT_W-2:0];
      side1 <= sq_side[ladlk_pkg::SQRT_STAGES];
      den2  <= p[ladlk_pkg::P_W-1 -: ladlk_pkg::PHI_W] * ladlk_pkg::FOUR_PI_Q28;
      side2 <= side1;
      n3    <= n_next;
      den3  <= den2;
      side3 <= side2;
    end
  end

  // The quotient must fit in OUT_W bits: the part of the numerator above
  // those bits has to stay below the denominator.
  always_comb begin
    r0              = n3[ladlk_pkg::N_W-1:ladlk_pkg::OUT_W];
    ovf             = (r0 >= ladlk_pkg::R0_W'(den3));
    d_init.rem      = ovf ? '0 : r0[ladlk_pkg::DEN_W-1:0];
    d_init.lo       = n3[ladlk_pkg::OUT_W-1:0];
    d_init.quo      = '0;
    d_init.den      = den3;
    d_init.neg      = side3.neg;
    d_init.singular = side3.singular;
    d_init.ovf      = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d[0] <= d_init;
    end
  end

  for (genvar g = 0; g < ladlk_pkg::DIV_STAGES; g++) begin : g_div
    ladlk_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv_v[g]),
      .in_d     (dv_d[g]),
      .out_valid(dv_v[g+1]),
      .out_d    (dv_d[g+1])
    );
  end

  always_comb begin
    fin   = dv_d[ladlk_pkg::DIV_STAGES];
    limit = fin.neg ? {1'b1, {(ladlk_pkg::OUT_W-1){1'b0}}}
                    : {1'b0, {(ladlk_pkg::OUT_W-1){1'b1}}};
    sat   = fin.ovf || (fin.quo > limit);
    qsat  = sat ? limit : fin.quo;
    val   = fin.neg ? -qsat : qsat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[ladlk_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kernel_value <= fin.singular ? '0 : val;
      singular     <= fin.singular;
      saturated    <= !fin.singular && sat;
    end
  end

endmodule
`default_nettype wire

// ----- src/ladlk_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module ladlk_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 out_valid,
  input wire                                 out_ready,
  input wire signed [ladlk_pkg::OUT_W-1:0]   kernel_value,
  input wire                                 singular,
  input wire                                 saturated
);

  // A result held back by the receiver keeps its value and flags.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(kernel_value) && $stable(singular) && $stable(saturated))
  // Coinciding points always give a clean zero.
  `ASSERT_CLK(a_singular_zero, out_valid && singular |-> kernel_value == '0 && !saturated)
  // A clipped value sits at one end of the range.
  `ASSERT_CLK(a_sat_end, out_valid && saturated |-> kernel_value == {1'b0, {(ladlk_pkg::OUT_W-1){1'b1}}} || kernel_value == {1'b1, {(ladlk_pkg::OUT_W-1){1'b0}}})
  // Nothing comes out in the cycle after reset.
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind laplace_adjoint_double_layer_kernel ladlk_checker u_checker (.*);
`default_nettype wire
